// ----- hw/rtl/bsps_pkg.sv -----
package bsps_pkg;

    // coordinate format, fixed by the field widths of the item
    localparam int COORD_BITS = 20;
    localparam int SIDE_BITS  = COORD_BITS + 1;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int RSQ_BITS   = 2 * SIDE_BITS;
    localparam int R2_BITS    = SQ_BITS + 2;
    localparam int KIND_BITS  = 2;
    localparam int NUM_KINDS  = 3;
    localparam int OUT_BITS   = 32;

    // configuration port
    localparam int CFG_DATA_BITS  = 63;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PACK_EXT_BITS  = CFG_DATA_BITS + 3 * SIDE_BITS;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_X     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Y     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTRE_Z     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_SIDES  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTER_SIDES  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INNER_RADIUS = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTER_RADIUS = 3'd6;

    // particle kinds
    localparam logic [KIND_BITS-1:0] KIND_GAS  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_DARK = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_STAR = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_NONE = 2'd3;

    // queue between classifier and counters
    localparam int QUEUE_DEPTH  = 8;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam int COUNT_BITS_DEFAULT = 32;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic signed [COORD_BITS-1:0] pos_z;
        logic [KIND_BITS-1:0]         particle_kind;
    } in_item_t;

    typedef struct packed {
        logic                keep;
        logic [OUT_BITS-1:0] particle_number;
        logic [OUT_BITS-1:0] kept_of_kind;
        logic [OUT_BITS-1:0] kept_total;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] centre_x;
        logic signed [COORD_BITS-1:0] centre_y;
        logic signed [COORD_BITS-1:0] centre_z;
        logic [CFG_DATA_BITS-1:0]     inner_box_sides;
        logic [CFG_DATA_BITS-1:0]     outer_box_sides;
        logic [SIDE_BITS-1:0]         inner_radius;
        logic [SIDE_BITS-1:0]         outer_radius;
    } cfg_t;

    // classified item as held in the queue
    typedef struct packed {
        logic                 keep;
        logic [KIND_BITS-1:0] kind;
    } class_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

// ----- hw/rtl/box_or_shell_particle_selector.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+----------------------------------
// item     | item_valid / item_ready    | item (pos_x, pos_y, pos_z, kind)
// result   | result_valid / result_ready| result (keep, number, counts)
// config   | cfg_write                  | cfg_index, cfg_data
//
// one item per cycle sustained while result_ready stays high
// the classifier is a pipeline (distance, squares, sum and compare)
// feeding an 8-entry queue; credits for that queue set item_ready
// reset clears the configuration, the counters and all valid state at once
// a stalled result holds the counters; items keep flowing until the credits run out
module box_or_shell_particle_selector #(
    parameter int COUNT_BITS = bsps_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  bsps_pkg::in_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output bsps_pkg::out_item_t                   result,
    input  logic                                  cfg_write,
    input  logic [bsps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [bsps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import bsps_pkg::*;

    cfg_t    cfg_reg;
    logic    push;
    class_t  push_data;
    logic    pop;
    class_t  head;
    q_stat_t q_stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CENTRE_X:     cfg_reg.centre_x        <= cfg_data[COORD_BITS-1:0];
                REG_CENTRE_Y:     cfg_reg.centre_y        <= cfg_data[COORD_BITS-1:0];
                REG_CENTRE_Z:     cfg_reg.centre_z        <= cfg_data[COORD_BITS-1:0];
                REG_INNER_SIDES:  cfg_reg.inner_box_sides <= cfg_data;
                REG_OUTER_SIDES:  cfg_reg.outer_box_sides <= cfg_data;
                REG_INNER_RADIUS: cfg_reg.inner_radius    <= cfg_data[SIDE_BITS-1:0];
                REG_OUTER_RADIUS: cfg_reg.outer_radius    <= cfg_data[SIDE_BITS-1:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // region classifier
    bsps_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg        (cfg_reg),
        .pop        (pop),
        .push       (push),
        .push_data  (push_data)
    );

    // queue of classified items
    bsps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // counters and output register
    bsps_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .stat         (q_stat),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // credits must keep the queue from overflowing
    assert property (@(posedge clk) disable iff (!rst_n) push |-> (!q_stat.full || pop))
        else $error("item pushed into a full queue");

    // nothing is taken from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.not_empty)
        else $error("pop from an empty queue");

    // a waiting item reaches a free output register in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_stat.not_empty && !result_valid) |=> result_valid)
        else $error("queued item not moved to the output");

endmodule

// ----- hw/rtl/bsps_front.sv -----
module bsps_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  bsps_pkg::in_item_t item,
    input  bsps_pkg::cfg_t    cfg,
    input  logic              pop,
    output logic              push,
    output bsps_pkg::class_t  push_data
);
    import bsps_pkg::*;

    logic accept;

    // items in flight in the classifier or waiting in the queue
    logic [QCOUNT_BITS-1:0] credit_reg, credit_next;

    // first stage: absolute distance per axis
    logic                 a_valid_reg;
    logic [DIFF_BITS-1:0] a_dist_reg [3];
    logic [KIND_BITS-1:0] a_kind_reg;
    logic [DIFF_BITS-1:0] dist_next [3];

    // second stage: squares and box flags
    logic                 b_valid_reg;
    logic [SQ_BITS-1:0]   b_sq_reg [3];
    logic                 b_in_outer_reg;
    logic                 b_in_inner_reg;
    logic [KIND_BITS-1:0] b_kind_reg;
    logic                 in_outer_next;
    logic                 in_inner_next;

    // radius squares follow the configuration
    logic [RSQ_BITS-1:0] ri_sq_reg;
    logic [RSQ_BITS-1:0] ro_sq_reg;

    logic [R2_BITS-1:0] r2;
    logic               box_mode;
    logic               region_hit;

    function automatic logic [DIFF_BITS-1:0] abs_diff(
        input logic [COORD_BITS-1:0] p,
        input logic [COORD_BITS-1:0] c
    );
        logic [DIFF_BITS-1:0] d;
        d = {p[COORD_BITS-1], p} - {c[COORD_BITS-1], c};
        return d[DIFF_BITS-1] ? (~d + DIFF_BITS'(1)) : d;
    endfunction

    function automatic logic [SIDE_BITS-1:0] side_of(
        input logic [CFG_DATA_BITS-1:0] packed_sides,
        input int                       axis
    );
        logic [PACK_EXT_BITS-1:0] ext;
        ext = {{(3 * SIDE_BITS){1'b0}}, packed_sides};
        return ext[axis * SIDE_BITS +: SIDE_BITS];
    endfunction

    assign accept     = item_valid && item_ready;
    assign item_ready = credit_reg < QCOUNT_BITS'(QUEUE_DEPTH);

    // credit count
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + QCOUNT_BITS'(1);
        end
        else if (pop && !accept)
        begin
            credit_next = credit_reg - QCOUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg  <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg  <= credit_next;
            a_valid_reg <= accept;
            b_valid_reg <= a_valid_reg;
        end
    end

    // distance from centre
    always_comb
    begin
        dist_next[0] = abs_diff(item.pos_x, cfg.centre_x);
        dist_next[1] = abs_diff(item.pos_y, cfg.centre_y);
        dist_next[2] = abs_diff(item.pos_z, cfg.centre_z);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int a = 0; a < 3; a++)
            begin
                a_dist_reg[a] <= dist_next[a];
            end
            a_kind_reg <= item.particle_kind;
        end
    end

    // per-axis box tests, twice the distance against the side
    always_comb
    begin
        in_outer_next = 1'b1;
        in_inner_next = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (!({a_dist_reg[a], 1'b0} < {1'b0, side_of(cfg.outer_box_sides, a)}))
            begin
                in_outer_next = 1'b0;
            end
            if (!({a_dist_reg[a], 1'b0} < {1'b0, side_of(cfg.inner_box_sides, a)}))
            begin
                in_inner_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            b_sq_reg[a] <= a_dist_reg[a] * a_dist_reg[a];
        end
        b_in_outer_reg <= in_outer_next;
        b_in_inner_reg <= in_inner_next;
        b_kind_reg     <= a_kind_reg;
        ri_sq_reg      <= cfg.inner_radius * cfg.inner_radius;
        ro_sq_reg      <= cfg.outer_radius * cfg.outer_radius;
    end

    // shell test on the summed squares, then the final decision
    assign r2 = R2_BITS'(b_sq_reg[0]) + R2_BITS'(b_sq_reg[1]) + R2_BITS'(b_sq_reg[2]);
    assign box_mode = (cfg.inner_radius == '0) && (cfg.outer_radius == '0);

    always_comb
    begin
        if (box_mode)
        begin
            region_hit = b_in_outer_reg && !b_in_inner_reg;
        end
        else
        begin
            region_hit = (r2 >= R2_BITS'(ri_sq_reg)) && (r2 < R2_BITS'(ro_sq_reg));
        end
    end

    assign push           = b_valid_reg;
    assign push_data.kind = b_kind_reg;
    assign push_data.keep = region_hit && (b_kind_reg != KIND_NONE);

endmodule

// ----- hw/rtl/bsps_queue.sv -----
module bsps_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsps_pkg::class_t  push_data,
    input  logic              pop,
    output bsps_pkg::class_t  head,
    output bsps_pkg::q_stat_t stat
);
    import bsps_pkg::*;

    class_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg;
    logic [QPTR_BITS-1:0]   rd_ptr_reg;
    logic [QCOUNT_BITS-1:0] count_reg;
    logic [QCOUNT_BITS-1:0] count_next;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCOUNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCOUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head           = entry_reg[rd_ptr_reg];
    assign stat.not_empty = count_reg != '0;
    assign stat.full      = count_reg == QCOUNT_BITS'(QUEUE_DEPTH);

endmodule

// ----- hw/rtl/bsps_back.sv -----
module bsps_back #(
    parameter int COUNT_BITS = bsps_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  bsps_pkg::class_t    head,
    input  bsps_pkg::q_stat_t   stat,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output bsps_pkg::out_item_t result
);
    import bsps_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [COUNT_BITS-1:0] seen_reg, seen_next;
    logic [COUNT_BITS-1:0] kind_cnt_reg [NUM_KINDS];
    logic [COUNT_BITS-1:0] kind_cnt_next [NUM_KINDS];
    logic [COUNT_BITS-1:0] sum_reg, sum_next;
    logic [COUNT_BITS-1:0] of_kind;
    logic                  result_valid_reg;
    out_item_t             result_reg;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] low_out(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+OUT_BITS-1:0] wide;
        wide = {{OUT_BITS{1'b0}}, v};
        return wide[OUT_BITS-1:0];
    endfunction

    // take the head when the output register is free or being emptied
    assign pop = stat.not_empty && (!result_valid_reg || result_ready);

    // counter updates
    always_comb
    begin
        seen_next = sat_inc(seen_reg);
        sum_next  = head.keep ? sat_inc(sum_reg) : sum_reg;
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            kind_cnt_next[k] = (head.keep && (head.kind == KIND_BITS'(k)))
                               ? sat_inc(kind_cnt_reg[k]) : kind_cnt_reg[k];
        end
        unique case (head.kind)
            KIND_GAS:  of_kind = kind_cnt_next[0];
            KIND_DARK: of_kind = kind_cnt_next[1];
            KIND_STAR: of_kind = kind_cnt_next[2];
            default:   of_kind = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                kind_cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                seen_reg <= seen_next;
                sum_reg  <= sum_next;
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    kind_cnt_reg[k] <= kind_cnt_next[k];
                end
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg.keep            <= head.keep;
            result_reg.particle_number <= low_out(seen_next);
            result_reg.kept_of_kind    <= low_out(of_kind);
            result_reg.kept_total      <= low_out(sum_next);
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
